/* src/gsten_pkg.sv */
// Shared types and constants of the iterated grid stencil core.
package gsten_pkg;

    // Grid edge length; the row and column fields are three bits wide, so 2 to 8.
    localparam int GRID_SIZE = 8;
    localparam int C_ROW_W   = $clog2(GRID_SIZE);
    localparam int C_K_W     = $clog2(GRID_SIZE + 1);
    localparam int C_VAL_W   = 32;

    localparam logic C_CMD_LOAD  = 1'b0;
    localparam logic C_CMD_START = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [2:0]          row;
        logic [2:0]          col;
        logic [C_VAL_W-1:0]  cell_value;
        logic [7:0]          days;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]          row_out;
        logic [2:0]          col_out;
        logic [C_VAL_W-1:0]  count;
        logic                last;
    } t_out_beat;

    // Control broadcast from the sequencer to every column cell.
    typedef struct packed {
        logic copy;
        logic shift;
        logic rot;
        logic first_row;
        logic last_row;
    } t_cell_ctl;

endpackage

/* src/gsten_in_if.sv */
// Input channel of the grid stencil core: valid, ready and one command beat.
interface gsten_in_if;
    import gsten_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/gsten_out_if.sv */
// Output channel of the grid stencil core: valid, ready and one cell beat.
interface gsten_out_if;
    import gsten_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/iterated_grid_stencil_core.sv */
// Top level of the iterated 3x3 stencil core with a zero boundary.
// A load beat writes one cell of the kept grid. A start beat copies the
// kept grid into the work columns in the cycle it is taken, then runs one
// sweep per day, in which the row of column cells sweeps the grid one row
// per cycle through a two-stage vertical and horizontal adder pipeline,
// with a drain step at the end of each day, and then delivers
// GRID_SIZE * GRID_SIZE result beats in raster order, one per cycle while
// the sink is ready. Beats are taken only while no start is in progress.
module iterated_grid_stencil_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsten_in_if.sink    i_in,
    gsten_out_if.source o_out
);
    import gsten_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DAY  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         r_state;
    logic [7:0]         r_days;
    logic [C_K_W-1:0]   r_k;
    logic [C_ROW_W-1:0] r_er;
    logic [C_ROW_W-1:0] r_ec;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic               w_acc;
    logic               w_load;
    logic               w_in_grid;
    logic               w_emit_step;
    t_cell_ctl          w_ctl;
    logic [C_VAL_W-1:0] w_v    [GRID_SIZE];
    logic [C_VAL_W-1:0] w_head [GRID_SIZE];

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_in_grid  = (32'(i_in.data.row) < GRID_SIZE) && (32'(i_in.data.col) < GRID_SIZE);
    assign w_load     = w_acc && (i_in.data.cmd == C_CMD_LOAD) && w_in_grid;

    assign w_emit_step = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_ctl           = '0;
        w_ctl.copy      = w_acc && (i_in.data.cmd == C_CMD_START);
        w_ctl.shift     = (r_state == S_DAY);
        w_ctl.rot       = w_emit_step && (r_ec == C_ROW_W'(GRID_SIZE - 1));
        w_ctl.first_row = (r_k == '0);
        w_ctl.last_row  = (r_k == C_K_W'(GRID_SIZE - 1));
    end

    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
        logic [C_VAL_W-1:0] w_vl;
        logic [C_VAL_W-1:0] w_vr;
        logic               w_sel;

        if (c == 0) begin : g_l0
            assign w_vl = '0;
        end else begin : g_ln
            assign w_vl = w_v[c-1];
        end
        if (c == GRID_SIZE - 1) begin : g_r0
            assign w_vr = '0;
        end else begin : g_rn
            assign w_vr = w_v[c+1];
        end

        assign w_sel = w_load && (32'(i_in.data.col) == c);

        gsten_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load_en  (w_sel),
            .i_load_row (i_in.data.row[C_ROW_W-1:0]),
            .i_load_val (i_in.data.cell_value),
            .i_v_left   (w_vl),
            .i_v_right  (w_vr),
            .o_v        (w_v[c]),
            .o_head     (w_head[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_days      <= '0;
            r_k         <= '0;
            r_er        <= '0;
            r_ec        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit_step) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_ctl.copy) begin
                        r_days  <= i_in.data.days;
                        r_k     <= '0;
                        r_er    <= '0;
                        r_ec    <= '0;
                        r_state <= (i_in.data.days == '0) ? S_EMIT : S_DAY;
                    end
                end
                S_DAY: begin
                    // The extra sweep step drains the last row out of the adders.
                    if (r_k == C_K_W'(GRID_SIZE)) begin
                        r_k    <= '0;
                        r_days <= r_days - 8'd1;
                        if (r_days == 8'd1) begin
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_k <= r_k + C_K_W'(1);
                    end
                end
                S_EMIT: begin
                    if (w_emit_step) begin
                        if (r_ec == C_ROW_W'(GRID_SIZE - 1)) begin
                            r_ec <= '0;
                            r_er <= r_er + C_ROW_W'(1);
                            if (r_er == C_ROW_W'(GRID_SIZE - 1)) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_ec <= r_ec + C_ROW_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_step) begin
            r_out.row_out <= 3'(r_er);
            r_out.col_out <= 3'(r_ec);
            r_out.count   <= w_head[r_ec];
            r_out.last    <= (r_er == C_ROW_W'(GRID_SIZE - 1)) &&
                             (r_ec == C_ROW_W'(GRID_SIZE - 1));
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_day_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAY) |-> (r_days != '0))
        else $error("day sweep running with no days left");

    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAY) |-> (r_k <= C_K_W'(GRID_SIZE)))
        else $error("row sweep counter out of range");

    // A following zero-day start may already be streaming its first cell.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.data.last && (r_state != S_EMIT))
        |=> !o_out.valid)
        else $error("beat delivered after the last cell of a grid");

    a_zero_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.data.cmd == C_CMD_START) && (i_in.data.days == '0))
        |=> (r_state == S_EMIT))
        else $error("start with zero days did not go straight to output");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && !r_out_valid |=> !o_out.valid)
        else $error("output beat appeared while no start was in progress");

endmodule

/* src/gsten_cell.sv */
// One grid column: loaded values, rotating work column and the stencil adders.
module gsten_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gsten_pkg::t_cell_ctl              i_ctl,
    input  logic                              i_load_en,
    input  logic [gsten_pkg::C_ROW_W-1:0]     i_load_row,
    input  logic [gsten_pkg::C_VAL_W-1:0]     i_load_val,
    input  logic [gsten_pkg::C_VAL_W-1:0]     i_v_left,
    input  logic [gsten_pkg::C_VAL_W-1:0]     i_v_right,
    output logic [gsten_pkg::C_VAL_W-1:0]     o_v,
    output logic [gsten_pkg::C_VAL_W-1:0]     o_head
);
    import gsten_pkg::*;

    logic [C_VAL_W-1:0] r_ld [GRID_SIZE];
    logic [C_VAL_W-1:0] r_s  [GRID_SIZE];
    logic [C_VAL_W-1:0] r_prev;
    logic [C_VAL_W-1:0] r_v;
    logic [C_VAL_W-1:0] r_mid;
    logic [C_VAL_W-1:0] w_up;
    logic [C_VAL_W-1:0] w_dn;
    logic [C_VAL_W-1:0] n_v;
    logic [C_VAL_W-1:0] w_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld <= '{default: '0};
        end else if (i_load_en) begin
            r_ld[i_load_row] <= i_load_val;
        end
    end

    // Rows above and below the grid count as zero.
    assign w_up = i_ctl.first_row ? '0 : r_prev;
    assign w_dn = i_ctl.last_row  ? '0 : r_s[1];
    assign n_v  = w_up + r_s[0] + w_dn;

    // Box sum of the 3x3 window plus the center once more gives twice the
    // center plus its eight neighbors.
    assign w_new = i_v_left + r_v + i_v_right + r_mid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.copy) begin
            r_s <= r_ld;
        end else if (i_ctl.shift) begin
            for (int i = 0; i < GRID_SIZE - 1; i++) begin
                r_s[i] <= r_s[i+1];
            end
            r_s[GRID_SIZE-1] <= w_new;
        end else if (i_ctl.rot) begin
            for (int i = 0; i < GRID_SIZE - 1; i++) begin
                r_s[i] <= r_s[i+1];
            end
            r_s[GRID_SIZE-1] <= r_s[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_prev <= r_s[0];
            r_v    <= n_v;
            r_mid  <= r_s[0];
        end
    end

    assign o_v    = r_v;
    assign o_head = r_s[0];

endmodule
